@@ src/sbvm_pkg.sv @@
// Shared types, opcodes and constants of the sixteen bit VM execute step
`default_nettype none
package sbvm_pkg;

  localparam int MEM_WORDS_DEF = 256;
  localparam int NUM_REGS      = 4;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 9;

  localparam logic [8:0] STACK_TOP  = 9'd256;
  localparam logic [8:0] RET_MAX_SP = 9'd250;
  localparam logic [9:0] FRAME_LEN  = 10'd6;

  // step operations
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_EXEC = 2'd1,
    OP_CTX  = 2'd2,
    OP_NONE = 2'd3
  } vm_op_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

  // instruction opcodes
  localparam logic [4:0] I_LD    = 5'd0;
  localparam logic [4:0] I_ST    = 5'd1;
  localparam logic [4:0] I_ADD   = 5'd2;
  localparam logic [4:0] I_ADDC  = 5'd3;
  localparam logic [4:0] I_SUB   = 5'd4;
  localparam logic [4:0] I_SUBC  = 5'd5;
  localparam logic [4:0] I_AND   = 5'd6;
  localparam logic [4:0] I_XOR   = 5'd7;
  localparam logic [4:0] I_NOT   = 5'd8;
  localparam logic [4:0] I_SHL   = 5'd9;
  localparam logic [4:0] I_SHLA  = 5'd10;
  localparam logic [4:0] I_SHR   = 5'd11;
  localparam logic [4:0] I_SHRA  = 5'd12;
  localparam logic [4:0] I_CMP   = 5'd13;
  localparam logic [4:0] I_GETST = 5'd14;
  localparam logic [4:0] I_PUTST = 5'd15;
  localparam logic [4:0] I_JMP   = 5'd16;
  localparam logic [4:0] I_JMPL  = 5'd17;
  localparam logic [4:0] I_JMPE  = 5'd18;
  localparam logic [4:0] I_JMPG  = 5'd19;
  localparam logic [4:0] I_CALL  = 5'd20;
  localparam logic [4:0] I_RET   = 5'd21;
  localparam logic [4:0] I_READ  = 5'd22;
  localparam logic [4:0] I_WRITE = 5'd23;
  localparam logic [4:0] I_HALT  = 5'd24;
  localparam logic [4:0] I_NOOP  = 5'd25;

  // stop codes
  localparam logic [2:0] RC_RUN    = 3'd0;
  localparam logic [2:0] RC_HALT   = 3'd1;
  localparam logic [2:0] RC_BOUNDS = 3'd2;
  localparam logic [2:0] RC_DATA   = 3'd3;
  localparam logic [2:0] RC_UNDER  = 3'd4;
  localparam logic [2:0] RC_BADOP  = 3'd5;
  localparam logic [2:0] RC_READ   = 3'd6;
  localparam logic [2:0] RC_WRITE  = 3'd7;

  // frame sequencing
  localparam logic [2:0] PUSH_LAST = 3'd5;
  localparam logic [2:0] POP_LAST  = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       setup;
    logic       exec;
    logic       ldwb;
    logic       push;
    logic       pop;
    logic [2:0] step;
    logic       publish;
  } sbvm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fetch_go;
    logic need_ldwb;
    logic need_push;
    logic need_pop;
    logic out_free;
  } sbvm_sts_t;

  function automatic logic [31:0] ext16(input logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  function automatic logic [31:0] with_code(input logic [31:0] sr, input logic [2:0] code);
    return {sr[31:8], code, sr[4:0]};
  endfunction

endpackage
`default_nettype wire

@@ src/sbvm_in_if.sv @@
// Input channel: step operation, address and data word
`default_nettype none
interface sbvm_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  operation;
  logic        [7:0]  address;
  logic signed [31:0] data_value;

  modport source (output valid, operation, address, data_value, input ready);
  modport sink   (input valid, operation, address, data_value, output ready);
endinterface
`default_nettype wire

@@ src/sbvm_out_if.sv @@
// Output channel: result of one step
`default_nettype none
interface sbvm_out_if;
  logic               valid;
  logic               ready;
  logic               stopped;
  logic        [2:0]  stop_reason;
  logic signed [31:0] status_word;
  logic               write_valid;
  logic signed [31:0] write_value;
  logic        [8:0]  program_counter;
  logic        [2:0]  cycles_taken;

  modport source (output valid, stopped, stop_reason, status_word, write_valid, write_value,
                  program_counter, cycles_taken, input ready);
  modport sink   (input valid, stopped, stop_reason, status_word, write_valid, write_value,
                  program_counter, cycles_taken, output ready);
endinterface
`default_nettype wire

@@ src/sbvm_datapath.sv @@
// Datapath: machine registers, word memory, execute logic and result register
`default_nettype none
module sbvm_datapath
  import sbvm_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sbvm_cmd_t             cmd,
  output sbvm_sts_t                  sts,
  input  wire logic [1:0]            operation,
  input  wire logic [7:0]            address,
  input  wire logic [31:0]           data_value,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic                       stopped,
  output logic [2:0]                 stop_reason,
  output logic [31:0]                status_word,
  output logic                       write_valid,
  output logic [31:0]                write_value,
  output logic [8:0]                 program_counter,
  output logic [2:0]                 cycles_taken
);

  localparam int         AW      = $clog2(MEM_WORDS);
  localparam logic [9:0] MEM_LIM = 10'(MEM_WORDS);

  // latched step inputs and configuration
  logic [1:0]  op_q;
  logic [7:0]  addr_q;
  logic [31:0] din_q;
  logic [7:0]  base_q;
  logic [8:0]  limit_q;

  // architectural state
  logic [31:0] regs [NUM_REGS];
  logic [31:0] regs_next [NUM_REGS];
  logic [8:0]  pc, pc_next;
  logic [8:0]  sp, sp_next;
  logic [31:0] sr, sr_next;

  // step outcome
  logic [2:0]  reason, reason_next;
  logic [2:0]  cyc, cyc_next;
  logic        wv, wv_next;
  logic [31:0] wval, wval_next;
  logic [15:0] ir;

  // memory port
  logic [31:0] mem [MEM_WORDS];
  logic [31:0] rdata;
  logic        oob;
  logic          mem_we, mem_re, mem_oob;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wd;

  // instruction fields, from read data in the execute cycle and from ir later
  logic [15:0] iw;
  logic [4:0]  opc;
  logic [1:0]  rd, rs;
  logic        imm;
  logic [7:0]  iaddr;
  logic [31:0] cst, opnd, rdv, addb, sum;
  logic        addc;
  logic [8:0]  tgt, sp_m1;
  logic        addr_bad, jmp_bad, pc_bad, sp_low, sp_high, carry, ovf;
  logic [31:0] pv;

  // execute results
  logic [31:0] x_r, x_sr, x_wval;
  logic        x_rwe, x_wv, x_mwe, x_mre, x_ldwb, x_push, x_pop;
  logic [8:0]  x_pc;
  logic [2:0]  x_code, x_cyc;

  assign iw    = cmd.exec ? rdata[15:0] : ir;
  assign opc   = iw[15:11];
  assign rd    = iw[10:9];
  assign imm   = iw[8];
  assign rs    = iw[7:6];
  assign iaddr = iw[7:0];
  assign cst   = {{24{iaddr[7]}}, iaddr};
  assign opnd  = imm ? cst : regs[rs];
  assign rdv   = regs[rd];
  assign tgt   = {1'b0, iaddr} + {1'b0, base_q};
  assign sp_m1 = sp - 9'd1;
  assign pv    = oob ? 32'd0 : rdata;

  assign jmp_bad  = {1'b0, iaddr} >= limit_q;
  assign addr_bad = jmp_bad || ({2'b00, iaddr} >= MEM_LIM);
  assign pc_bad   = ({1'b0, pc} >= ({2'b00, base_q} + {1'b0, limit_q})) ||
                    ({1'b0, pc} >= MEM_LIM);
  assign sp_low   = {1'b0, sp} < ({1'b0, limit_q} + FRAME_LEN);
  assign sp_high  = sp > RET_MAX_SP;

  // shared adder for add, sub and their carry forms
  always_comb begin
    addb = opnd;
    addc = 1'b0;
    case (opc)
      I_ADDC: addc = sr[0];
      I_SUB: begin
        addb = ~opnd;
        addc = 1'b1;
      end
      I_SUBC: begin
        addb = ~opnd;
        addc = ~sr[0];
      end
      default: addb = opnd;
    endcase
  end
  assign sum   = rdv + addb + {31'd0, addc};
  assign carry = sum[16];
  assign ovf   = (opc == I_ADD) ? (rdv[15] == opnd[15] && rdv[15] != sum[15])
                                : (rdv[15] != opnd[15] && opnd[15] == sum[15]);

  // execute one fetched instruction
  always_comb begin
    x_r    = rdv;
    x_rwe  = 1'b0;
    x_sr   = sr;
    x_pc   = pc + 9'd1;
    x_code = RC_RUN;
    x_cyc  = 3'd1;
    x_wv   = 1'b0;
    x_wval = 32'd0;
    x_mwe  = 1'b0;
    x_mre  = 1'b0;
    x_ldwb = 1'b0;
    x_push = 1'b0;
    x_pop  = 1'b0;
    case (opc)
      I_LD: begin
        if (imm) begin
          x_r   = cst;
          x_rwe = 1'b1;
        end else if (addr_bad) begin
          x_code = RC_DATA;
        end else begin
          x_mre  = 1'b1;
          x_ldwb = 1'b1;
          x_cyc  = 3'd4;
        end
      end
      I_ST: begin
        if (addr_bad) begin
          x_code = RC_DATA;
        end else begin
          x_mwe = 1'b1;
          x_cyc = 3'd4;
        end
      end
      I_ADD, I_SUB: begin
        x_r   = ext16(sum);
        x_rwe = 1'b1;
        x_sr  = ovf ? ({sr[31:1], carry} | 32'h10) : {28'd0, sr[3:1], carry};
      end
      I_ADDC, I_SUBC: begin
        x_r   = ext16(sum);
        x_rwe = 1'b1;
        x_sr  = {sr[31:1], carry};
      end
      I_AND: begin
        x_r   = {16'd0, rdv[15:0] & opnd[15:0]};
        x_rwe = 1'b1;
      end
      I_XOR: begin
        x_r   = {16'd0, rdv[15:0] ^ opnd[15:0]};
        x_rwe = 1'b1;
      end
      I_NOT: begin
        x_r   = {16'd0, ~rdv[15:0]};
        x_rwe = 1'b1;
      end
      I_SHL: begin
        x_r   = {rdv[30:0], 1'b0};
        x_rwe = 1'b1;
        x_sr  = {sr[31:1], rdv[15]};
      end
      I_SHLA: begin
        x_rwe = 1'b1;
        x_sr  = {sr[31:1], rdv[15]};
        x_r   = rdv[15] ? {rdv[30:0], 1'b0} | 32'h8000 : {17'd0, rdv[13:0], 1'b0};
      end
      I_SHR: begin
        x_r   = {17'd0, rdv[15:1]};
        x_rwe = 1'b1;
        x_sr  = {sr[31:1], rdv[0]};
      end
      I_SHRA: begin
        x_r   = {rdv[31], rdv[31:1]};
        x_rwe = 1'b1;
        x_sr  = {sr[31:1], rdv[0]};
      end
      // compare clears overflow and rewrites the three flags
      I_CMP: begin
        x_sr = {sr[31:5], 1'b0, ($signed(rdv) < $signed(opnd)), (rdv == opnd),
                ($signed(rdv) > $signed(opnd)), sr[0]};
      end
      I_GETST: begin
        x_r   = sr;
        x_rwe = 1'b1;
      end
      I_PUTST: x_sr = rdv;
      I_JMP, I_JMPL, I_JMPE, I_JMPG: begin
        if (opc == I_JMP || (opc == I_JMPL && sr[3]) || (opc == I_JMPE && sr[2]) ||
            (opc == I_JMPG && sr[1])) begin
          x_pc = tgt;
        end
        if (jmp_bad) begin
          x_code = RC_BOUNDS;
        end
      end
      I_CALL: begin
        if (jmp_bad) begin
          x_code = RC_BOUNDS;
        end else if (sp_low) begin
          x_code = RC_DATA;
        end else begin
          x_push = 1'b1;
          x_cyc  = 3'd4;
        end
      end
      I_RET: begin
        if (sp_high) begin
          x_code = RC_UNDER;
        end else begin
          x_pop = 1'b1;
          x_cyc = 3'd4;
        end
      end
      I_READ, I_WRITE: begin
        x_cyc = 3'd2;
        x_sr  = {sr[31:12], 2'b00, rd, sr[7:0]};
        if (opc == I_READ) begin
          x_r    = din_q;
          x_rwe  = 1'b1;
          x_code = RC_READ;
        end else begin
          x_wv   = 1'b1;
          x_wval = rdv;
          x_code = RC_WRITE;
        end
      end
      I_HALT: x_code = RC_HALT;
      I_NOOP: begin
        if (jmp_bad) begin
          x_code = RC_BOUNDS;
        end
      end
      default: x_code = RC_BADOP;
    endcase
    if (x_code != RC_RUN) begin
      x_sr = with_code(x_sr, x_code);
    end
  end

  // next state per command
  always_comb begin
    regs_next   = regs;
    pc_next     = pc;
    sp_next     = sp;
    sr_next     = sr;
    reason_next = reason;
    cyc_next    = cyc;
    wv_next     = wv;
    wval_next   = wval;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_oob     = 1'b0;
    mem_addr    = addr_q[AW-1:0];
    mem_wd      = din_q;
    if (cmd.accept) begin
      reason_next = RC_RUN;
      cyc_next    = 3'd0;
      wv_next     = 1'b0;
      wval_next   = 32'd0;
    end
    if (cmd.setup) begin
      case (op_q)
        OP_LOAD: mem_we = ({2'b00, addr_q} < MEM_LIM);
        OP_CTX: begin
          pc_next = {1'b0, addr_q};
          sp_next = STACK_TOP;
          sr_next = 32'd0;
        end
        OP_EXEC: begin
          if (pc_bad) begin
            reason_next = RC_BOUNDS;
            sr_next     = with_code(sr, RC_BOUNDS);
          end else begin
            mem_re   = 1'b1;
            mem_addr = pc[AW-1:0];
          end
        end
        default: mem_we = 1'b0;
      endcase
    end
    if (cmd.exec) begin
      if (x_rwe) begin
        regs_next[rd] = x_r;
      end
      sr_next     = x_sr;
      pc_next     = x_pc;
      reason_next = x_code;
      cyc_next    = x_cyc;
      wv_next     = x_wv;
      wval_next   = x_wval;
      mem_addr    = iaddr[AW-1:0];
      mem_wd      = rdv;
      mem_we      = x_mwe;
      mem_re      = x_mre;
    end
    if (cmd.ldwb) begin
      regs_next[rd] = rdata;
    end
    // frame push: return pc, r0..r3, then status
    if (cmd.push) begin
      sp_next  = sp_m1;
      mem_addr = sp_m1[AW-1:0];
      mem_we   = ({1'b0, sp_m1} < MEM_LIM);
      case (cmd.step)
        3'd0:    mem_wd = {23'd0, pc};
        3'd1:    mem_wd = regs[0];
        3'd2:    mem_wd = regs[1];
        3'd3:    mem_wd = regs[2];
        3'd4:    mem_wd = regs[3];
        default: mem_wd = sr;
      endcase
      if (cmd.step == PUSH_LAST) begin
        pc_next = tgt;
      end
    end
    // frame pop: read ahead one word, capture the previous read
    if (cmd.pop) begin
      if (cmd.step != POP_LAST) begin
        mem_re   = 1'b1;
        mem_oob  = ({1'b0, sp} >= MEM_LIM);
        mem_addr = sp[AW-1:0];
        sp_next  = sp + 9'd1;
      end
      case (cmd.step)
        3'd1:    sr_next      = pv;
        3'd2:    regs_next[3] = pv;
        3'd3:    regs_next[2] = pv;
        3'd4:    regs_next[1] = pv;
        3'd5:    regs_next[0] = pv;
        3'd6:    pc_next      = pv[8:0];
        default: sr_next      = sr;
      endcase
    end
  end

  assign sts.fetch_go  = (op_q == OP_EXEC) && !pc_bad;
  assign sts.need_ldwb = x_ldwb;
  assign sts.need_push = x_push;
  assign sts.need_pop  = x_pop;
  assign sts.out_free  = !out_valid || out_ready;

  // word memory, one port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
      oob   <= mem_oob;
    end
  end

  // input latch, instruction and outcome
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= operation;
      addr_q <= address;
      din_q  <= data_value;
    end
    if (cmd.exec) begin
      ir <= rdata[15:0];
    end
    reason <= reason_next;
    cyc    <= cyc_next;
    wv     <= wv_next;
    wval   <= wval_next;
  end

  // machine state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= 32'd0;
      end
      pc      <= 9'd0;
      sp      <= STACK_TOP;
      sr      <= 32'd0;
      base_q  <= 8'd0;
      limit_q <= 9'd0;
    end else begin
      regs <= regs_next;
      pc   <= pc_next;
      sp   <= sp_next;
      sr   <= sr_next;
      if (cfg_we && cfg_index == CFG_BASE) begin
        base_q <= cfg_data[7:0];
      end
      if (cfg_we && cfg_index == CFG_LIMIT) begin
        limit_q <= cfg_data[8:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      stopped         <= (reason != RC_RUN);
      stop_reason     <= reason;
      status_word     <= sr;
      write_valid     <= wv;
      write_value     <= wval;
      program_counter <= pc;
      cycles_taken    <= cyc;
    end
  end

endmodule
`default_nettype wire

@@ src/sbvm_ctrl.sv @@
// Controller: step sequencing state machine
`default_nettype none
module sbvm_ctrl
  import sbvm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire sbvm_sts_t sts,
  output sbvm_cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_LDWB  = 7'b0001000,
    S_PUSH  = 7'b0010000,
    S_POP   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic [2:0] step, step_next;

  assign in_ready = (state == S_IDLE);

  // commands and next state
  always_comb begin
    state_next  = state;
    step_next   = step;
    cmd         = '0;
    cmd.step    = step;
    case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = sts.fetch_go ? S_EXEC : S_DONE;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        step_next = 3'd0;
        if (sts.need_ldwb) begin
          state_next = S_LDWB;
        end else if (sts.need_push) begin
          state_next = S_PUSH;
        end else if (sts.need_pop) begin
          state_next = S_POP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LDWB: begin
        cmd.ldwb   = 1'b1;
        state_next = S_DONE;
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        step_next = step + 3'd1;
        if (step == PUSH_LAST) begin
          state_next = S_DONE;
        end
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        step_next = step + 3'd1;
        if (step == POP_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.publish = sts.out_free;
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 3'd0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

`ifndef SYNTH
  a_accept_setup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SETUP))
    else $error("accepted transfer did not start setup");
  a_push_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) |-> (step <= PUSH_LAST))
    else $error("push frame overran");
  a_pop_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP && step == POP_LAST) |=> (state == S_DONE))
    else $error("pop frame did not finish");
  a_publish: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && sts.out_free) |=> (state == S_IDLE))
    else $error("result not published when slot free");
`endif

endmodule
`default_nettype wire

@@ src/sixteen_bit_vm_execute_step.sv @@
// Top level: sixteen bit VM execute step, controller plus datapath
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   operation, address, data_value
//  out_ch   out  valid/ready   stopped, stop_reason, status_word, write_valid,
//                              write_value, program_counter, cycles_taken
//  cfg      in   cfg_we        cfg_index, cfg_data
//
// One item at a time. Load, set context and a pc fault go from setup straight to the result;
// an instruction adds an execute step, a memory load adds a writeback step, and call
// and return move six frame words through the single memory port.
// Synchronous active-high reset clears registers, pc, sp = 256, status, config.
// Memory content is undefined until written. A result waiting on out_ch stalls
// only the final step; the next item is accepted once it has left.
`default_nettype none
module sixteen_bit_vm_execute_step
  import sbvm_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  sbvm_in_if.sink                    in_ch,
  sbvm_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  sbvm_cmd_t cmd;
  sbvm_sts_t sts;

  sbvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbvm_datapath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .operation       (in_ch.operation),
    .address         (in_ch.address),
    .data_value      (in_ch.data_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .stopped         (out_ch.stopped),
    .stop_reason     (out_ch.stop_reason),
    .status_word     (out_ch.status_word),
    .write_valid     (out_ch.write_valid),
    .write_value     (out_ch.write_value),
    .program_counter (out_ch.program_counter),
    .cycles_taken    (out_ch.cycles_taken)
  );

endmodule
`default_nettype wire

@@ tb/sv/sixteen_bit_vm_execute_step_tb.sv @@
// Self-checking testbench for the sixteen bit VM execute step, with a built-in machine predictor
`default_nettype none
module sixteen_bit_vm_execute_step_tb;
  import sbvm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MEM_N      = 256;
  localparam int          RAND_ITEMS = 1360;
  localparam int          CYC_LIMIT  = 600000;
  localparam logic [4:0]  I_BAD      = 5'd31;

  typedef struct packed {
    logic        stopped;
    logic [2:0]  reason;
    logic [31:0] sr;
    logic        wv;
    logic [31:0] wval;
    logic [8:0]  pc;
    logic [2:0]  cyc;
  } step_res_t;

  typedef struct packed {
    vm_op_t     op;
    logic [7:0] addr;
    logic [5:0] reps;
    logic       set_limit;
    logic       typed;
    step_res_t  res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BASE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  sbvm_in_if  in_ch ();
  sbvm_out_if out_ch ();

  sixteen_bit_vm_execute_step dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // machine state mirror
  logic [31:0] m_mem [0:MEM_N-1];
  logic [31:0] m_reg [0:3];
  int unsigned m_pc, m_sp, m_base, m_limit;
  logic [31:0] m_sr;

  step_res_t   pending_q [$];
  int          err_cnt = 0;
  int          item_cnt = 0;
  int          exec_cnt = 0;
  int          result_cnt = 0;
  int          stop_cnt = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          cycle_cnt = 0;

  function automatic logic [2:0] set_rc(input logic [2:0] code);
    m_sr[7:5] = code;
    return code;
  endfunction

  function automatic logic [31:0] mem_rd(input int unsigned idx);
    return (idx < MEM_N) ? m_mem[idx] : 32'd0;
  endfunction

  // one fetched instruction; returns the stop code
  function automatic logic [2:0] run_instr(input logic [31:0] din, output logic [2:0] cyc,
                                           output logic wv, output logic [31:0] wval);
    logic [31:0] ir, cst, opnd, res, s1, s2, r;
    logic [4:0]  opc;
    logic [1:0]  rd;
    logic [7:0]  ad;
    logic        ovf, taken;
    cyc = 3'd0;
    wv = 1'b0;
    wval = 32'd0;
    if (m_pc >= m_base + m_limit || m_pc >= MEM_N) return set_rc(RC_BOUNDS);
    ir = m_mem[m_pc];
    m_pc = (m_pc + 1) & 9'h1ff;
    opc = ir[15:11];
    rd = ir[10:9];
    ad = ir[7:0];
    cst = {{24{ad[7]}}, ad};
    opnd = ir[8] ? cst : m_reg[ir[7:6]];
    r = m_reg[rd];
    cyc = 3'd1;
    case (opc)
      I_LD: begin
        if (ir[8]) r = cst;
        else begin
          if (ad >= m_limit) return set_rc(RC_DATA);
          r = m_mem[ad];
          cyc = 3'd4;
        end
      end
      I_ST: begin
        if (ad >= m_limit) return set_rc(RC_DATA);
        m_mem[ad] = r;
        cyc = 3'd4;
      end
      I_ADD, I_SUB: begin
        res = (opc == I_ADD) ? r + opnd : r - opnd;
        m_sr[0] = res[16];
        ovf = (opc == I_ADD) ? (r[15] == opnd[15] && r[15] != res[15])
                             : (r[15] != opnd[15] && opnd[15] == res[15]);
        if (ovf) m_sr[4] = 1'b1;
        else m_sr = m_sr & 32'hf;
        r = {{16{res[15]}}, res[15:0]};
      end
      I_ADDC, I_SUBC: begin
        res = (opc == I_ADDC) ? r + opnd + {31'd0, m_sr[0]} : r - opnd - {31'd0, m_sr[0]};
        m_sr[0] = res[16];
        r = {{16{res[15]}}, res[15:0]};
      end
      I_AND: r = (r & opnd) & 32'hffff;
      I_XOR: r = (r ^ opnd) & 32'hffff;
      I_NOT: r = ~r & 32'hffff;
      I_SHL: begin
        r = r << 1;
        m_sr[0] = r[16];
      end
      I_SHLA: begin
        r = r << 1;
        m_sr[0] = r[16];
        if (r[16]) r = r | 32'h8000;
        else r = r & 32'h7fff;
      end
      I_SHR: begin
        r = r & 32'hffff;
        m_sr[0] = r[0];
        r = r >> 1;
      end
      I_SHRA: begin
        m_sr[0] = r[0];
        r = (r >> 1) | (r & 32'h8000_0000);
      end
      I_CMP: begin
        m_sr = m_sr & 32'hffff_ffe1;
        s1 = r ^ 32'h8000_0000;
        s2 = opnd ^ 32'h8000_0000;
        if (s1 < s2) m_sr[3] = 1'b1;
        if (s1 == s2) m_sr[2] = 1'b1;
        if (s1 > s2) m_sr[1] = 1'b1;
      end
      I_GETST: r = m_sr;
      I_PUTST: m_sr = r;
      I_JMP, I_JMPL, I_JMPE, I_JMPG: begin
        taken = (opc == I_JMP) || (opc == I_JMPL && m_sr[3]) ||
                (opc == I_JMPE && m_sr[2]) || (opc == I_JMPG && m_sr[1]);
        // target is taken before the bounds check
        if (taken) m_pc = (ad + m_base) & 9'h1ff;
        if (ad >= m_limit) return set_rc(RC_BOUNDS);
      end
      I_CALL: begin
        if (ad >= m_limit) return set_rc(RC_BOUNDS);
        if (m_sp < m_limit + 6) return set_rc(RC_DATA);
        m_sp--; if (m_sp < MEM_N) m_mem[m_sp] = m_pc;
        for (int j = 0; j < 4; j++) begin
          m_sp--; if (m_sp < MEM_N) m_mem[m_sp] = m_reg[j];
        end
        m_sp--; if (m_sp < MEM_N) m_mem[m_sp] = m_sr;
        m_pc = (ad + m_base) & 9'h1ff;
        cyc = 3'd4;
      end
      I_RET: begin
        if (m_sp > 250) return set_rc(RC_UNDER);
        m_sr = mem_rd(m_sp); m_sp++;
        for (int j = 3; j >= 0; j--) begin
          m_reg[j] = mem_rd(m_sp); m_sp++;
        end
        m_pc = mem_rd(m_sp) & 9'h1ff; m_sp++;
        cyc = 3'd4;
        return RC_RUN;
      end
      I_READ, I_WRITE: begin
        if (opc == I_READ) begin
          m_reg[rd] = din;
        end else begin
          wv = 1'b1;
          wval = r;
        end
        cyc = 3'd2;
        m_sr = (m_sr & 32'hffff_f01f) | ({30'd0, rd} << 8);
        return set_rc(opc == I_READ ? RC_READ : RC_WRITE);
      end
      I_HALT: return set_rc(RC_HALT);
      I_NOOP: if (ad >= m_limit) return set_rc(RC_BOUNDS);
      default: return set_rc(RC_BADOP);
    endcase
    m_reg[rd] = r;
    return RC_RUN;
  endfunction

  function automatic step_res_t predict_step(input vm_op_t op, input logic [7:0] a,
                                             input logic [31:0] din);
    step_res_t res;
    logic [2:0] code;
    res = '0;
    case (op)
      OP_LOAD: m_mem[a] = din;
      OP_CTX: begin
        m_pc = a;
        m_sp = 256;
        m_sr = '0;
      end
      OP_EXEC: begin
        code = run_instr(din, res.cyc, res.wv, res.wval);
        res.stopped = (code != RC_RUN);
        res.reason = code;
      end
      default: ;
    endcase
    res.sr = m_sr;
    res.pc = m_pc[8:0];
    return res;
  endfunction

  function automatic logic [31:0] enc(input logic [4:0] op, input logic [1:0] rd,
                                     input logic i, input logic [7:0] low);
    logic [31:0] u;
    u = $urandom;
    return {u[31:16], op, rd, i, low};
  endfunction

  // random instruction word, targets biased into the limit window
  function automatic logic [31:0] rand_instr();
    logic [4:0] op;
    logic [7:0] low;
    int unsigned hi;
    op = ($urandom_range(99) < 6) ? 5'($urandom_range(31, 26)) : 5'($urandom_range(25));
    low = 8'($urandom);
    hi = (m_limit > MEM_N) ? MEM_N - 1 : m_limit - 1;
    if (m_limit > 0 && $urandom_range(3) != 0) low = 8'($urandom_range(hi));
    return enc(op, 2'($urandom), 1'($urandom), low);
  endfunction

  // word of the directed program at a given address
  function automatic logic [31:0] prog_word(input int unsigned a);
    case (a)
      0:  return enc(I_LD,    2'd0, 1'b1, 8'hff);
      1:  return enc(I_LD,    2'd1, 1'b1, 8'h7f);
      2:  return enc(I_ADD,   2'd1, 1'b0, 8'h40);
      3:  return enc(I_ADDC,  2'd0, 1'b1, 8'h01);
      4:  return enc(I_SUB,   2'd0, 1'b0, 8'h40);
      5:  return enc(I_SUBC,  2'd1, 1'b1, 8'h80);
      6:  return enc(I_AND,   2'd0, 1'b1, 8'hf0);
      7:  return enc(I_XOR,   2'd1, 1'b0, 8'h00);
      8:  return enc(I_NOT,   2'd0, 1'b0, 8'h00);
      9:  return enc(I_SHL,   2'd1, 1'b0, 8'h00);
      10: return enc(I_SHLA,  2'd0, 1'b0, 8'h00);
      11: return enc(I_SHR,   2'd1, 1'b0, 8'h00);
      12: return enc(I_SHRA,  2'd0, 1'b0, 8'h00);
      13: return enc(I_CMP,   2'd1, 1'b1, 8'h05);
      14: return enc(I_GETST, 2'd2, 1'b0, 8'h00);
      15: return enc(I_PUTST, 2'd3, 1'b0, 8'h00);
      16: return enc(I_ST,    2'd0, 1'b0, 8'd200);
      17: return enc(I_LD,    2'd2, 1'b0, 8'd200);
      18: return enc(I_JMPL,  2'd0, 1'b0, 8'd20);
      19: return enc(I_JMP,   2'd0, 1'b0, 8'd20);
      20: return enc(I_CALL,  2'd0, 1'b0, 8'd24);
      21: return enc(I_READ,  2'd3, 1'b0, 8'h00);
      22: return enc(I_WRITE, 2'd3, 1'b0, 8'h00);
      23: return enc(I_HALT,  2'd0, 1'b0, 8'h00);
      24: return enc(I_RET,   2'd0, 1'b0, 8'h00);
      25: return enc(I_BAD,   2'd0, 1'b0, 8'h00);
      26: return enc(I_JMPE,  2'd0, 1'b0, 8'd27);
      27: return enc(I_JMPG,  2'd0, 1'b0, 8'd28);
      28: return enc(I_NOOP,  2'd0, 1'b0, 8'd29);
      29: return enc(I_LD,    2'd0, 1'b1, 8'h80);
      default: return $urandom;
    endcase
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", result_cnt, what, got, want);
    err_cnt++;
  endtask

  // one transfer on the input channel; prediction at the accepting edge
  task automatic send_item(input vm_op_t op, input logic [7:0] a, input logic [31:0] din,
                           input logic typed, input step_res_t typed_res);
    step_res_t res;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.address    <= a;
    in_ch.data_value <= din;
    do @(posedge clk); while (!in_ch.ready);
    res = predict_step(op, a, din);
    pending_q.push_back(typed ? typed_res : res);
    item_cnt++;
    if (op == OP_EXEC) exec_cnt++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (15) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BASE) m_base = val & 8'hff;
    else m_limit = val & 9'h1ff;
  endtask

  // random items: program loads, context switches, runs of execution and random operations
  task automatic random_phase(input int n_items);
    int unsigned lo, hi, burst;
    int stop_at;
    stop_at = item_cnt + n_items;
    lo = m_base;
    hi = (m_base + m_limit > MEM_N) ? MEM_N - 1 : m_base + m_limit - 1;
    while (item_cnt < stop_at) begin
      case ($urandom_range(9))
        0:
          send_item(vm_op_t'($urandom_range(3)), 8'($urandom), $urandom, 1'b0, '0);
        1, 2:
          send_item(OP_LOAD, (lo <= hi) ? 8'($urandom_range(hi, lo)) : 8'($urandom),
                    rand_instr(), 1'b0, '0);
        3:
          send_item(OP_CTX, (lo <= hi && $urandom_range(7) != 0) ?
                    8'($urandom_range(hi, lo)) : 8'($urandom), $urandom, 1'b0, '0);
        default: begin
          burst = $urandom_range(12, 1);
          repeat (burst) send_item(OP_EXEC, 8'($urandom), $urandom, 1'b0, '0);
        end
      endcase
    end
  endtask

  // receiver backpressure
  always @(negedge clk) out_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle);

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    step_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      result_cnt++;
      if (out_ch.stopped) stop_cnt++;
      if (pending_q.size() == 0) begin
        report("unexpected result transfer", 32'd1, 32'd0);
      end else begin
        want = pending_q.pop_front();
        if (out_ch.stopped !== want.stopped) report("stopped", out_ch.stopped, want.stopped);
        if (out_ch.stop_reason !== want.reason)
          report("stop_reason", out_ch.stop_reason, want.reason);
        if (out_ch.status_word !== want.sr) report("status_word", out_ch.status_word, want.sr);
        if (out_ch.write_valid !== want.wv) report("write_valid", out_ch.write_valid, want.wv);
        if (out_ch.write_value !== want.wval)
          report("write_value", out_ch.write_value, want.wval);
        if (out_ch.program_counter !== want.pc)
          report("program_counter", out_ch.program_counter, want.pc);
        if (out_ch.cycles_taken !== want.cyc)
          report("cycles_taken", out_ch.cycles_taken, want.cyc);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  dir_row_t dir_tab [0:5];

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_NONE;
    in_ch.address    = '0;
    in_ch.data_value = '0;
    out_ch.ready     = 1'b0;
    for (int k = 0; k < 4; k++) m_reg[k] = '0;
    m_pc = 0; m_sp = 256; m_sr = '0; m_base = 0; m_limit = 0;

    // limit zero stops before any fetch; context, first program steps, a none operation and a top load follow
    dir_tab = '{
      '{OP_EXEC, 8'd0, 6'd1,  1'b0, 1'b1, '{1'b1, RC_BOUNDS, 32'h40, 1'b0, 32'd0, 9'd0, 3'd0}},
      '{OP_CTX,  8'd0, 6'd1,  1'b0, 1'b1, '{1'b0, RC_RUN, 32'd0, 1'b0, 32'd0, 9'd0, 3'd0}},
      '{OP_EXEC, 8'd0, 6'd1,  1'b1, 1'b1, '{1'b0, RC_RUN, 32'd0, 1'b0, 32'd0, 9'd1, 3'd1}},
      '{OP_EXEC, 8'd0, 6'd30, 1'b0, 1'b0, '0},
      '{OP_NONE, 8'd7, 6'd1,  1'b0, 1'b0, '0},
      '{OP_LOAD, 8'd255, 6'd1, 1'b0, 1'b0, '0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // every memory word is written before anything can read it
    send_idle = 13;
    recv_idle = 83;
    for (int a = 0; a < MEM_N; a++) send_item(OP_LOAD, 8'(a), prog_word(a), 1'b0, '0);

    foreach (dir_tab[n]) begin
      if (dir_tab[n].set_limit) begin
        drain();
        write_cfg(CFG_LIMIT, 256);
      end
      repeat (dir_tab[n].reps)
        send_item(dir_tab[n].op, dir_tab[n].addr, $urandom, dir_tab[n].typed, dir_tab[n].res);
    end

    // phases of configuration and handshake pressure
    random_phase(RAND_ITEMS / 4);
    drain();
    send_idle = 83;
    recv_idle = 13;
    write_cfg(CFG_BASE, 128);
    write_cfg(CFG_LIMIT, 200);
    random_phase(RAND_ITEMS / 4);
    drain();
    send_idle = 0;
    recv_idle = 0;
    write_cfg(CFG_BASE, 255);
    write_cfg(CFG_LIMIT, 256);
    random_phase(RAND_ITEMS / 8);
    drain();
    write_cfg(CFG_BASE, $urandom_range(255));
    write_cfg(CFG_LIMIT, $urandom_range(256));
    random_phase(RAND_ITEMS / 4);
    drain();
    write_cfg(CFG_BASE, 0);
    write_cfg(CFG_LIMIT, 0);
    random_phase(RAND_ITEMS / 8);
    drain();

    $display("%0d input transfers (%0d executed), %0d results checked, %0d stops",
             item_cnt, exec_cnt, result_cnt, stop_cnt);
    $display("covered base/limit extremes and three idle patterns, %0d mismatches", err_cnt);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
